>>> src/mqtt_packet_field_parser_core_defines.svh
// Assertion macros for the checker of the MQTT field parser.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef MQTT_PACKET_FIELD_PARSER_CORE_DEFINES_SVH
`define MQTT_PACKET_FIELD_PARSER_CORE_DEFINES_SVH

// Check a consequence in the same cycle as its trigger.
`define MQPFP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("parser property violated in the same cycle");

// Check a consequence in the cycle after its trigger.
`define MQPFP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("parser property violated one cycle later");

`endif

>>> src/mqpfp_pkg.sv
package mqpfp_pkg;

	// Default number of remaining-length bytes before the length is malformed
	localparam int unsigned MAX_LENGTH_BYTES_DEF = 4;

	// Control packet type that carries a topic and payload
	localparam logic [3:0] KIND_PUBLISH = 4'd3;
	// Range of packet types that carry a fixed packet id
	localparam logic [3:0] KIND_ID_FIRST = 4'd4;
	localparam logic [3:0] KIND_ID_LAST  = 4'd11;

	// Byte roles
	localparam logic [2:0] ROLE_HEADER    = 3'd0;
	localparam logic [2:0] ROLE_LENGTH    = 3'd1;
	localparam logic [2:0] ROLE_TOPIC_LEN = 3'd2;
	localparam logic [2:0] ROLE_TOPIC     = 3'd3;
	localparam logic [2:0] ROLE_PACKET_ID = 3'd4;
	localparam logic [2:0] ROLE_BODY      = 3'd5;
	localparam logic [2:0] ROLE_PAST_END  = 3'd6;

	// Status codes
	localparam logic [1:0] STATUS_IN_PROGRESS = 2'd0;
	localparam logic [1:0] STATUS_COMPLETE    = 2'd1;
	localparam logic [1:0] STATUS_TRUNCATED   = 2'd2;
	localparam logic [1:0] STATUS_MALFORMED   = 2'd3;

	// Varint byte layout
	localparam logic [7:0] LEN_VALUE_MASK = 8'h7f;
	localparam logic [7:0] LEN_CONT_MASK  = 8'h80;

	typedef struct packed {
		logic [2:0]  byte_role;
		logic [3:0]  packet_kind;
		logic [1:0]  service_level;
		logic [28:0] total_length;
		logic [15:0] topic_length;
		logic [15:0] packet_id;
		logic [27:0] payload_length;
		logic [1:0]  status;
	} result_t;

endpackage

>>> src/mqpfp_in_if.sv
interface mqpfp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       packet_start;
	logic       last_available;

	modport source (output valid, output rx_byte, output packet_start,
		output last_available, input ready);
	modport sink (input valid, input rx_byte, input packet_start,
		input last_available, output ready);
endinterface

>>> src/mqpfp_out_if.sv
interface mqpfp_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  byte_role;
	logic [3:0]  packet_kind;
	logic [1:0]  service_level;
	logic [28:0] total_length;
	logic [15:0] topic_length;
	logic [15:0] packet_id;
	logic [27:0] payload_length;
	logic [1:0]  status;

	modport source (output valid, output byte_role, output packet_kind,
		output service_level, output total_length, output topic_length,
		output packet_id, output payload_length, output status, input ready);
	modport sink (input valid, input byte_role, input packet_kind,
		input service_level, input total_length, input topic_length,
		input packet_id, input payload_length, input status, output ready);
endinterface

>>> src/mqtt_packet_field_parser_core.sv
// MQTT fixed-header and PUBLISH field parser.
// rx carries one received packet byte per request, with packet_start on the
// first byte of a packet and last_available on the last byte now buffered.
// parsed carries one result per request: the byte's role, the packet type
// and QoS, the running total length, topic length, packet id, payload count
// and a status (in progress, complete, truncated, malformed).
// Each accepted request's result loads into the result register on the
// accepting edge. Throughput: one byte per cycle while parsed does not
// stall; the parse state loads on the same accepting edge, so the loop
// through the parse state holds no extra register.
// rx.ready looks through the result register: a new request is taken
// whenever the register is empty or is drained in the same cycle.
// When parsed stalls, the result holds and rx.ready drops until it drains.
// Reset (arst_n low) empties the result register and returns the parser to
// idle, where bytes without packet_start report past-end role, status zero.
module mqtt_packet_field_parser_core #(
	parameter int unsigned MAX_LENGTH_BYTES = mqpfp_pkg::MAX_LENGTH_BYTES_DEF
) (
	input logic         clk,
	input logic         arst_n,
	mqpfp_in_if.sink    rx,
	mqpfp_out_if.source parsed
);

	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_LEN   = 3'd1;
	localparam logic [2:0] PH_TLEN  = 3'd2;
	localparam logic [2:0] PH_TOPIC = 3'd3;
	localparam logic [2:0] PH_PID   = 3'd4;
	localparam logic [2:0] PH_BODY  = 3'd5;
	localparam logic [2:0] PH_END   = 3'd6;
	localparam logic [2:0] PH_BAD   = 3'd7;

	logic [2:0]  phase_q, phase_d;
	logic [3:0]  kind_q, kind_d;
	logic [1:0]  level_q, level_d;
	logic [27:0] accum_q, accum_d;
	logic [2:0]  lbc_q, lbc_d;
	logic [28:0] bpos_q, bpos_d;
	logic [15:0] tlen_q, tlen_d;
	logic [15:0] tcnt_q, tcnt_d;
	logic [15:0] id_q, id_d;
	logic [27:0] pay_q, pay_d;

	logic                res_valid_q;
	mqpfp_pkg::result_t  res_q;
	mqpfp_pkg::result_t  res_d;

	logic        accept;
	logic        is_publish;
	logic        has_fixed_id;
	logic [2:0]  after_topic;
	logic [27:0] len_bits;
	logic [6:0]  len_val;
	logic        len_cont;
	logic        hi;
	logic        half;
	logic        fin;
	logic [28:0] total_sum;
	logic [2:0]  role;
	logic [1:0]  stat;

	assign accept   = rx.valid && rx.ready;
	assign rx.ready = !res_valid_q || parsed.ready;

	assign is_publish   = (kind_q == mqpfp_pkg::KIND_PUBLISH);
	assign has_fixed_id = (kind_q >= mqpfp_pkg::KIND_ID_FIRST) &&
		(kind_q <= mqpfp_pkg::KIND_ID_LAST);
	assign after_topic  = (level_q != 2'd0) ? PH_PID : PH_BODY;
	assign len_val      = 7'(rx.rx_byte & mqpfp_pkg::LEN_VALUE_MASK);
	assign len_cont     = (rx.rx_byte & mqpfp_pkg::LEN_CONT_MASK) != 8'd0;

	// Place the 7-bit length group at its varint position
	always_comb begin
		case (lbc_q[1:0])
			2'd0:    len_bits = {21'd0, len_val};
			2'd1:    len_bits = {14'd0, len_val, 7'd0};
			2'd2:    len_bits = {7'd0, len_val, 14'd0};
			default: len_bits = {len_val, 21'd0};
		endcase
	end

	// Advance the parse state for one byte and build its result
	always_comb begin
		phase_d   = phase_q;
		kind_d    = kind_q;
		level_d   = level_q;
		accum_d   = accum_q;
		lbc_d     = lbc_q;
		bpos_d    = bpos_q;
		tlen_d    = tlen_q;
		tcnt_d    = tcnt_q;
		id_d      = id_q;
		pay_d     = pay_q;
		role      = mqpfp_pkg::ROLE_PAST_END;
		stat      = mqpfp_pkg::STATUS_IN_PROGRESS;
		hi        = 1'b0;
		half      = 1'b0;
		fin       = 1'b0;
		total_sum = '0;

		if (rx.packet_start) begin
			phase_d = PH_LEN;
			kind_d  = rx.rx_byte[7:4];
			level_d = rx.rx_byte[2:1];
			accum_d = '0;
			lbc_d   = '0;
			bpos_d  = 29'd1;
			tlen_d  = '0;
			tcnt_d  = '0;
			id_d    = '0;
			pay_d   = '0;
			role    = mqpfp_pkg::ROLE_HEADER;
			stat    = rx.last_available ? mqpfp_pkg::STATUS_TRUNCATED :
				mqpfp_pkg::STATUS_IN_PROGRESS;
		end else begin
			case (phase_q)
				PH_LEN: begin
					role   = mqpfp_pkg::ROLE_LENGTH;
					bpos_d = bpos_q + 29'd1;
					if (len_cont && (32'(lbc_q) + 32'd1 >= 32'(MAX_LENGTH_BYTES))) begin
						accum_d = '0;
						lbc_d   = '0;
						phase_d = PH_BAD;
						stat    = mqpfp_pkg::STATUS_MALFORMED;
					end else begin
						accum_d = accum_q | len_bits;
						lbc_d   = lbc_q + 3'd1;
						if (len_cont) begin
							stat = rx.last_available ? mqpfp_pkg::STATUS_TRUNCATED :
								mqpfp_pkg::STATUS_IN_PROGRESS;
						end else begin
							if (is_publish)
								phase_d = PH_TLEN;
							else if (has_fixed_id && (lbc_q == 3'd0))
								phase_d = PH_PID;
							else
								phase_d = PH_BODY;
							fin = 1'b1;
						end
					end
				end
				PH_TLEN: begin
					role = mqpfp_pkg::ROLE_TOPIC_LEN;
					hi   = (bpos_q == 29'd1 + 29'(lbc_q));
					if (hi) begin
						tlen_d = {8'd0, rx.rx_byte};
					end else begin
						tlen_d  = {tlen_q[7:0], rx.rx_byte};
						phase_d = (tlen_d != 16'd0) ? PH_TOPIC : after_topic;
					end
					bpos_d = bpos_q + 29'd1;
					half   = hi;
					fin    = 1'b1;
				end
				PH_TOPIC: begin
					role   = mqpfp_pkg::ROLE_TOPIC;
					tcnt_d = tcnt_q + 16'd1;
					if (tcnt_d == tlen_q)
						phase_d = after_topic;
					bpos_d = bpos_q + 29'd1;
					fin    = 1'b1;
				end
				PH_PID: begin
					role = mqpfp_pkg::ROLE_PACKET_ID;
					if (is_publish)
						hi = (bpos_q == 29'd3 + 29'(lbc_q) + 29'(tlen_q));
					else
						hi = (bpos_q == 29'd2);
					if (hi) begin
						id_d = {8'd0, rx.rx_byte};
					end else begin
						id_d    = {id_q[7:0], rx.rx_byte};
						phase_d = PH_BODY;
					end
					bpos_d = bpos_q + 29'd1;
					half   = hi;
					fin    = 1'b1;
				end
				PH_BODY: begin
					role = mqpfp_pkg::ROLE_BODY;
					if (is_publish)
						pay_d = pay_q + 28'd1;
					bpos_d = bpos_q + 29'd1;
					fin    = 1'b1;
				end
				PH_END: begin
					stat = mqpfp_pkg::STATUS_COMPLETE;
				end
				PH_BAD: begin
					stat = mqpfp_pkg::STATUS_MALFORMED;
				end
				default: begin
					stat = mqpfp_pkg::STATUS_IN_PROGRESS;
				end
			endcase
		end

		total_sum = 29'(accum_d) + 29'(lbc_d) + 29'd1;

		// Close the packet once the byte count reaches the total length
		if (fin) begin
			if (bpos_d >= total_sum) begin
				if (half) begin
					if (phase_d == PH_TLEN)
						tlen_d = '0;
					else
						id_d = '0;
				end
				if (is_publish && ((phase_d == PH_TLEN) || (phase_d == PH_TOPIC) ||
					(phase_d == PH_PID))) begin
					phase_d = PH_BAD;
					stat    = mqpfp_pkg::STATUS_MALFORMED;
				end else begin
					phase_d = PH_END;
					stat    = mqpfp_pkg::STATUS_COMPLETE;
				end
			end else begin
				stat = rx.last_available ? mqpfp_pkg::STATUS_TRUNCATED :
					mqpfp_pkg::STATUS_IN_PROGRESS;
			end
		end

		res_d.byte_role      = role;
		res_d.packet_kind    = kind_d;
		res_d.service_level  = level_d;
		res_d.total_length   = ((phase_d == PH_IDLE) || (phase_d == PH_LEN) ||
			(lbc_d == 3'd0)) ? 29'd0 : total_sum;
		res_d.topic_length   = (phase_d == PH_TLEN) ? 16'd0 : tlen_d;
		res_d.packet_id      = (phase_d == PH_PID) ? 16'd0 : id_d;
		res_d.payload_length = pay_d;
		res_d.status         = stat;
	end

	// Hold parse state; advance on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			kind_q  <= '0;
			level_q <= '0;
			accum_q <= '0;
			lbc_q   <= '0;
			bpos_q  <= '0;
			tlen_q  <= '0;
			tcnt_q  <= '0;
			id_q    <= '0;
			pay_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			kind_q  <= kind_d;
			level_q <= level_d;
			accum_q <= accum_d;
			lbc_q   <= lbc_d;
			bpos_q  <= bpos_d;
			tlen_q  <= tlen_d;
			tcnt_q  <= tcnt_d;
			id_q    <= id_d;
			pay_q   <= pay_d;
		end
	end

	// Result valid: set on accept, drop when drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (parsed.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Load result payload on accept
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end
	end

	assign parsed.valid          = res_valid_q;
	assign parsed.byte_role      = res_q.byte_role;
	assign parsed.packet_kind    = res_q.packet_kind;
	assign parsed.service_level  = res_q.service_level;
	assign parsed.total_length   = res_q.total_length;
	assign parsed.topic_length   = res_q.topic_length;
	assign parsed.packet_id      = res_q.packet_id;
	assign parsed.payload_length = res_q.payload_length;
	assign parsed.status         = res_q.status;

endmodule

>>> src/mqpfp_checker.sv
`include "mqtt_packet_field_parser_core_defines.svh"

module mqpfp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rx_valid,
	input logic        rx_ready,
	input logic [7:0]  rx_byte,
	input logic        packet_start,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  byte_role,
	input logic [3:0]  packet_kind,
	input logic [28:0] total_length,
	input logic [15:0] topic_length,
	input logic [15:0] packet_id,
	input logic [27:0] payload_length,
	input logic [1:0]  status
);

	// Every accepted request yields a result on the next cycle
	`MQPFP_ASSERT_NEXT(a_request_gives_result, rx_valid && rx_ready, out_valid)

	// A start byte comes back as a header carrying its upper nibble as the type
	`MQPFP_ASSERT_NEXT(a_start_latches_kind, rx_valid && rx_ready && packet_start, (byte_role == mqpfp_pkg::ROLE_HEADER) && (packet_kind == $past(rx_byte[7:4])))

	// A header result starts with all running fields cleared
	`MQPFP_ASSERT_NOW(a_header_clears_fields, out_valid && (byte_role == mqpfp_pkg::ROLE_HEADER), (total_length == 29'd0) && (topic_length == 16'd0) && (packet_id == 16'd0) && (payload_length == 28'd0))

	// Bytes past the end are never reported as truncated
	`MQPFP_ASSERT_NOW(a_past_end_not_truncated, out_valid && (byte_role == mqpfp_pkg::ROLE_PAST_END), status != mqpfp_pkg::STATUS_TRUNCATED)

	// A stalled result holds
	`MQPFP_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(byte_role) && $stable(status) && $stable(total_length))

endmodule

bind mqtt_packet_field_parser_core mqpfp_checker u_mqpfp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rx_valid       (rx.valid),
	.rx_ready       (rx.ready),
	.rx_byte        (rx.rx_byte),
	.packet_start   (rx.packet_start),
	.out_valid      (parsed.valid),
	.out_ready      (parsed.ready),
	.byte_role      (parsed.byte_role),
	.packet_kind    (parsed.packet_kind),
	.total_length   (parsed.total_length),
	.topic_length   (parsed.topic_length),
	.packet_id      (parsed.packet_id),
	.payload_length (parsed.payload_length),
	.status         (parsed.status)
);

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int unsigned CLK_HALF       = 4;
	localparam int unsigned RESET_CYCLES   = 7;
	localparam int unsigned RANDOM_ITEMS   = 650;
	localparam int unsigned QUIET_LIMIT    = 2000;
	localparam int unsigned HOLD_AFTER     = 150;
	localparam int unsigned HOLD_CYCLES    = 60;
	localparam int unsigned CALM_FIRST     = 300;
	localparam int unsigned CALM_LAST      = 420;
	localparam int unsigned IDLE_PERCENT   = 19;
	localparam int unsigned DRAIN_CYCLES   = 10;
	localparam int unsigned PRINT_LIMIT    = 100;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LENGTH,
		ST_TOPIC_LEN,
		ST_TOPIC,
		ST_PACKET_ID,
		ST_BODY,
		ST_DONE,
		ST_BROKEN
	} parse_phase_t;

	typedef struct {
		logic [7:0] data;
		logic       begins_packet;
		logic       end_of_buffer;
	} rx_request_t;

	// Tracks the parse of the byte stream and holds the field sets still owed
	class field_parse_tracker;
		parse_phase_t        phase;
		logic [3:0]          kind;
		logic [1:0]          level;
		logic [27:0]         length_sum;
		logic [2:0]          length_bytes;
		logic [28:0]         position;
		logic [15:0]         topic_len;
		logic [15:0]         topic_seen;
		logic [15:0]         id_value;
		logic [27:0]         payload_seen;
		mqpfp_pkg::result_t  expected_fields[$];
		int unsigned         mismatches;
		int unsigned         results_seen;

		function new();
			mismatches = 0;
			results_seen = 0;
			clear_packet();
		endfunction

		function void clear_packet();
			phase = ST_IDLE;
			kind = '0;
			level = '0;
			length_sum = '0;
			length_bytes = '0;
			position = '0;
			topic_len = '0;
			topic_seen = '0;
			id_value = '0;
			payload_seen = '0;
		endfunction

		function int unsigned pending();
			return expected_fields.size();
		endfunction

		function logic [28:0] total_so_far();
			if (phase == ST_IDLE || phase == ST_LENGTH || length_bytes == 0)
				return '0;
			return 29'(length_sum) + 29'(length_bytes) + 29'd1;
		endfunction

		function parse_phase_t after_topic();
			return (level != 0) ? ST_PACKET_ID : ST_BODY;
		endfunction

		// Close the packet once the byte count reaches the total length
		function logic [1:0] close_out(logic ends, logic half_field);
			if (position >= total_so_far()) begin
				if (half_field) begin
					if (phase == ST_TOPIC_LEN)
						topic_len = '0;
					else
						id_value = '0;
				end
				if (kind == mqpfp_pkg::KIND_PUBLISH && (phase == ST_TOPIC_LEN ||
					phase == ST_TOPIC || phase == ST_PACKET_ID)) begin
					phase = ST_BROKEN;
					return mqpfp_pkg::STATUS_MALFORMED;
				end
				phase = ST_DONE;
				return mqpfp_pkg::STATUS_COMPLETE;
			end
			return ends ? mqpfp_pkg::STATUS_TRUNCATED : mqpfp_pkg::STATUS_IN_PROGRESS;
		endfunction

		// Advance the parse by one accepted request and queue its fields
		function void note_request(logic [7:0] data, logic begins, logic ends);
			logic [2:0]          role;
			logic [1:0]          verdict;
			logic                high_half;
			mqpfp_pkg::result_t  fields;
			role = mqpfp_pkg::ROLE_PAST_END;
			verdict = mqpfp_pkg::STATUS_IN_PROGRESS;
			if (begins) begin
				clear_packet();
				kind = data[7:4];
				level = data[2:1];
				position = 29'd1;
				phase = ST_LENGTH;
				role = mqpfp_pkg::ROLE_HEADER;
				verdict = ends ? mqpfp_pkg::STATUS_TRUNCATED : mqpfp_pkg::STATUS_IN_PROGRESS;
			end else begin
				case (phase)
					ST_LENGTH: begin
						role = mqpfp_pkg::ROLE_LENGTH;
						position++;
						if ((data & mqpfp_pkg::LEN_CONT_MASK) != 0 &&
							32'(length_bytes) + 1 >= mqpfp_pkg::MAX_LENGTH_BYTES_DEF) begin
							length_sum = '0;
							length_bytes = '0;
							phase = ST_BROKEN;
							verdict = mqpfp_pkg::STATUS_MALFORMED;
						end else begin
							length_sum |= 28'(data & mqpfp_pkg::LEN_VALUE_MASK) <<
								(7 * length_bytes[1:0]);
							length_bytes++;
							if ((data & mqpfp_pkg::LEN_CONT_MASK) != 0) begin
								verdict = ends ? mqpfp_pkg::STATUS_TRUNCATED :
									mqpfp_pkg::STATUS_IN_PROGRESS;
							end else begin
								if (kind == mqpfp_pkg::KIND_PUBLISH)
									phase = ST_TOPIC_LEN;
								else if (kind >= mqpfp_pkg::KIND_ID_FIRST &&
									kind <= mqpfp_pkg::KIND_ID_LAST &&
									length_bytes == 3'd1)
									phase = ST_PACKET_ID;
								else
									phase = ST_BODY;
								verdict = close_out(ends, 1'b0);
							end
						end
					end
					ST_TOPIC_LEN: begin
						role = mqpfp_pkg::ROLE_TOPIC_LEN;
						high_half = (position == 29'(length_bytes) + 29'd1);
						if (high_half) begin
							topic_len = {8'h00, data};
						end else begin
							topic_len = {topic_len[7:0], data};
							phase = (topic_len != 0) ? ST_TOPIC : after_topic();
						end
						position++;
						verdict = close_out(ends, high_half);
					end
					ST_TOPIC: begin
						role = mqpfp_pkg::ROLE_TOPIC;
						topic_seen++;
						if (topic_seen == topic_len)
							phase = after_topic();
						position++;
						verdict = close_out(ends, 1'b0);
					end
					ST_PACKET_ID: begin
						role = mqpfp_pkg::ROLE_PACKET_ID;
						if (kind == mqpfp_pkg::KIND_PUBLISH)
							high_half = (position ==
								29'(length_bytes) + 29'(topic_len) + 29'd3);
						else
							high_half = (position == 29'd2);
						if (high_half) begin
							id_value = {8'h00, data};
						end else begin
							id_value = {id_value[7:0], data};
							phase = ST_BODY;
						end
						position++;
						verdict = close_out(ends, high_half);
					end
					ST_BODY: begin
						role = mqpfp_pkg::ROLE_BODY;
						if (kind == mqpfp_pkg::KIND_PUBLISH)
							payload_seen++;
						position++;
						verdict = close_out(ends, 1'b0);
					end
					ST_DONE: verdict = mqpfp_pkg::STATUS_COMPLETE;
					ST_BROKEN: verdict = mqpfp_pkg::STATUS_MALFORMED;
					default: verdict = mqpfp_pkg::STATUS_IN_PROGRESS;
				endcase
			end
			fields.byte_role = role;
			fields.packet_kind = kind;
			fields.service_level = level;
			fields.total_length = total_so_far();
			fields.topic_length = (phase == ST_TOPIC_LEN) ? 16'h0000 : topic_len;
			fields.packet_id = (phase == ST_PACKET_ID) ? 16'h0000 : id_value;
			fields.payload_length = payload_seen;
			fields.status = verdict;
			expected_fields.push_back(fields);
		endfunction

		task report_mismatch(string msg);
			if (mismatches < PRINT_LIMIT)
				$display("mismatch: %s", msg);
			mismatches++;
		endtask

		task compare_field(string name, int unsigned got_v, int unsigned want_v);
			if (got_v != want_v)
				report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
					results_seen, name, got_v, want_v));
		endtask

		// Compare one result against the oldest field set still owed
		task check_fields(mqpfp_pkg::result_t got);
			mqpfp_pkg::result_t want;
			results_seen++;
			if (expected_fields.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with nothing expected",
					results_seen));
				return;
			end
			want = expected_fields.pop_front();
			compare_field("byte_role", 32'(got.byte_role), 32'(want.byte_role));
			compare_field("packet_kind", 32'(got.packet_kind), 32'(want.packet_kind));
			compare_field("service_level", 32'(got.service_level),
				32'(want.service_level));
			compare_field("total_length", 32'(got.total_length), 32'(want.total_length));
			compare_field("topic_length", 32'(got.topic_length), 32'(want.topic_length));
			compare_field("packet_id", 32'(got.packet_id), 32'(want.packet_id));
			compare_field("payload_length", 32'(got.payload_length),
				32'(want.payload_length));
			compare_field("status", 32'(got.status), 32'(want.status));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	mqpfp_in_if rx();
	mqpfp_out_if parsed();

	mqtt_packet_field_parser_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx),
		.parsed(parsed)
	);

	field_parse_tracker tracker;
	rx_request_t        byte_stream[$];
	int unsigned        requests_in = 0;
	int unsigned        results_out = 0;
	int unsigned        quiet_cycles = 0;

	always #(CLK_HALF) clk = ~clk;

	function automatic logic buffer_ends();
		return $urandom_range(0, 9) == 0;
	endfunction

	task automatic push_byte(logic [7:0] data, logic begins, logic ends);
		rx_request_t item;
		item.data = data;
		item.begins_packet = begins;
		item.end_of_buffer = ends;
		byte_stream.push_back(item);
	endtask

	// Encode a remaining length, low group first
	task automatic push_length(int unsigned value);
		logic [7:0] group;
		do begin
			group = {1'b0, value[6:0]};
			value = value >> 7;
			if (value != 0)
				group = group | mqpfp_pkg::LEN_CONT_MASK;
			push_byte(group, 1'b0, buffer_ends());
		end while (value != 0);
	endtask

	// Append one packet: mostly well formed, some short, overlong, huge or noise
	task automatic add_random_packet();
		logic [7:0]  content[$];
		logic [7:0]  head;
		int unsigned pick;
		int unsigned shape;
		int unsigned count;
		int unsigned declared;
		int unsigned n_cont;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			head[7:4] = mqpfp_pkg::KIND_PUBLISH;
		else if (pick < 80)
			head[7:4] = 4'($urandom_range(mqpfp_pkg::KIND_ID_FIRST, mqpfp_pkg::KIND_ID_LAST));
		else
			head[7:4] = 4'($urandom_range(0, 15));
		head[3:0] = 4'($urandom);
		if (head[7:4] == mqpfp_pkg::KIND_PUBLISH) begin
			count = $urandom_range(0, 6);
			content.push_back(8'h00);
			content.push_back(8'(count));
			repeat (count) content.push_back(8'($urandom));
			if (head[2:1] != 0)
				repeat (2) content.push_back(8'($urandom));
			repeat ($urandom_range(0, 8)) content.push_back(8'($urandom));
		end else if (head[7:4] >= mqpfp_pkg::KIND_ID_FIRST &&
			head[7:4] <= mqpfp_pkg::KIND_ID_LAST) begin
			repeat (2 + $urandom_range(0, 3)) content.push_back(8'($urandom));
		end else begin
			repeat ($urandom_range(0, 4)) content.push_back(8'($urandom));
		end
		shape = $urandom_range(0, 99);
		push_byte(head, 1'b1, buffer_ends());
		if (shape < 78) begin
			push_length(content.size());
			foreach (content[i]) push_byte(content[i], 1'b0, buffer_ends());
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(1, 2)) push_byte(8'($urandom), 1'b0, buffer_ends());
		end else if (shape < 86) begin
			declared = (content.size() == 0) ? 0 : $urandom_range(0, content.size() - 1);
			push_length(declared);
			foreach (content[i]) push_byte(content[i], 1'b0, buffer_ends());
		end else if (shape < 92) begin
			n_cont = $urandom_range(1, mqpfp_pkg::MAX_LENGTH_BYTES_DEF);
			repeat (n_cont) push_byte({1'b1, 7'($urandom)}, 1'b0, buffer_ends());
			if (n_cont < mqpfp_pkg::MAX_LENGTH_BYTES_DEF)
				push_byte({1'b0, 7'($urandom)}, 1'b0, buffer_ends());
			foreach (content[i]) push_byte(content[i], 1'b0, buffer_ends());
		end else if (shape < 97) begin
			push_length($urandom_range(128, 28'hfffffff));
			if (head[7:4] == mqpfp_pkg::KIND_PUBLISH) begin
				content[0] = 8'($urandom);
				content[1] = 8'($urandom);
			end
			foreach (content[i]) push_byte(content[i], 1'b0, buffer_ends());
			repeat ($urandom_range(0, 6)) push_byte(8'($urandom), 1'b0, buffer_ends());
		end else begin
			repeat ($urandom_range(1, 6))
				push_byte(8'($urandom), $urandom_range(0, 7) == 0, buffer_ends());
		end
	endtask

	// Reset, then offer every request of the stream with random gaps
	initial begin : stimulus
		int unsigned directed_count;
		int unsigned idx;
		bit          calm;
		tracker = new();
		arst_n <= 1'b0;
		rx.valid <= 1'b0;
		rx.rx_byte <= 8'h00;
		rx.packet_start <= 1'b0;
		rx.last_available <= 1'b0;

		// byte before any packet
		push_byte(8'h5a, 1'b0, 1'b0);
		// PUBLISH QoS 1 with topic, id and payload; buffer ends inside topic; one past end
		push_byte(8'h32, 1'b1, 1'b0);
		push_byte(8'h07, 1'b0, 1'b0);
		push_byte(8'h00, 1'b0, 1'b0);
		push_byte(8'h02, 1'b0, 1'b0);
		push_byte(8'h61, 1'b0, 1'b1);
		push_byte(8'h62, 1'b0, 1'b0);
		push_byte(8'h12, 1'b0, 1'b0);
		push_byte(8'h34, 1'b0, 1'b0);
		push_byte(8'hff, 1'b0, 1'b0);
		push_byte(8'h00, 1'b0, 1'b0);
		// all-ones header truncated, then zero length
		push_byte(8'hff, 1'b1, 1'b1);
		push_byte(8'h00, 1'b0, 1'b0);
		// overlong remaining length
		push_byte(8'h30, 1'b1, 1'b0);
		push_byte(8'h80, 1'b0, 1'b0);
		push_byte(8'h80, 1'b0, 1'b0);
		push_byte(8'h80, 1'b0, 1'b0);
		push_byte(8'h80, 1'b0, 1'b0);
		// ack with id, buffer ends in length
		push_byte(8'h40, 1'b1, 1'b0);
		push_byte(8'h02, 1'b0, 1'b1);
		push_byte(8'hab, 1'b0, 1'b0);
		push_byte(8'hcd, 1'b0, 1'b0);
		// ack ending before the whole id
		push_byte(8'h62, 1'b1, 1'b0);
		push_byte(8'h01, 1'b0, 1'b0);
		push_byte(8'hab, 1'b0, 1'b0);
		// publish ending inside topic length
		push_byte(8'h3c, 1'b1, 1'b0);
		push_byte(8'h01, 1'b0, 1'b0);
		push_byte(8'h00, 1'b0, 1'b0);
		directed_count = byte_stream.size();
		while (byte_stream.size() < directed_count + RANDOM_ITEMS)
			add_random_packet();

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		for (idx = 0; idx < byte_stream.size(); idx++) begin
			calm = (idx >= CALM_FIRST && idx < CALM_LAST);
			while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
				rx.valid <= 1'b0;
				@(posedge clk);
			end
			rx.valid <= 1'b1;
			rx.rx_byte <= byte_stream[idx].data;
			rx.packet_start <= byte_stream[idx].begins_packet;
			rx.last_available <= byte_stream[idx].end_of_buffer;
			do @(posedge clk); while (!rx.ready);
		end
		rx.valid <= 1'b0;

		// drain every result, then allow the result register to settle
		while (results_out < byte_stream.size()) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

	// Stall the result side at random, with one long hold-off and one calm stretch
	initial begin : drain
		bit held;
		held = 1'b0;
		parsed.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!held && requests_in >= HOLD_AFTER) begin
				held = 1'b1;
				parsed.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (results_out >= CALM_FIRST && results_out < CALM_LAST) begin
				parsed.ready <= 1'b1;
			end else begin
				parsed.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
			end
		end
	end

	// Sample both handshakes, feed the tracker and watch for a hang
	always @(posedge clk) begin : monitor
		mqpfp_pkg::result_t got;
		if (arst_n) begin
			if (parsed.valid && parsed.ready) begin
				got.byte_role = parsed.byte_role;
				got.packet_kind = parsed.packet_kind;
				got.service_level = parsed.service_level;
				got.total_length = parsed.total_length;
				got.topic_length = parsed.topic_length;
				got.packet_id = parsed.packet_id;
				got.payload_length = parsed.payload_length;
				got.status = parsed.status;
				tracker.check_fields(got);
				results_out <= results_out + 1;
			end
			if (rx.valid && rx.ready) begin
				tracker.note_request(rx.rx_byte, rx.packet_start, rx.last_available);
				requests_in <= requests_in + 1;
			end
			if ((parsed.valid && parsed.ready) || (rx.valid && rx.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb_top failed");
				$finish;
			end
		end
	end
endmodule

>>> filelist.f
+incdir+src
src/mqpfp_pkg.sv
src/mqpfp_in_if.sv
src/mqpfp_out_if.sv
src/mqtt_packet_field_parser_core.sv
src/mqpfp_checker.sv
test/tb_top.sv
